// File: hdl/alc_pkg.sv
// Package for the ambient light lux calculator.
// Holds widths, status and register codes, lookup functions and the
// structs that pass between the front end and the divider cells.
package alc_pkg;

    // Field widths
    localparam int COUNT_W   = 16;
    localparam int LUX_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int TCODE_W   = 3;
    localparam int GCODE_W   = 2;
    localparam int DF_W      = 10;
    localparam int CFG_IDX_W = 2;

    // Default overflow threshold on either channel
    localparam int COUNT_MAX_DEF = 65535;

    // Internal arithmetic widths
    localparam int TMS_W   = 10;                 // integration time in ms, up to 600
    localparam int GAIN_W  = 15;                 // doubled gain, up to 18400
    localparam int K_W     = 24;                 // time_ms * gain2, up to 11040000
    localparam int SQ_W    = 2 * COUNT_W;        // visible squared
    localparam int NUM_SHIFT = 9;                // 256 * 2 from scale and doubled gain
    localparam int NUM_W   = SQ_W + DF_W + NUM_SHIFT;   // 51
    localparam int DEN_W   = COUNT_W + K_W;      // 40
    localparam int HI_W    = NUM_W - LUX_W;      // numerator bits above the quotient

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_CODE = 2'd0,
        CFG_GAIN_CODE = 2'd1,
        CFG_LUX_DF    = 2'd2
    } t_cfg_idx;

    // Per-item fields carried alongside the division
    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   vis;
        logic                 force_zero;
        logic                 sat;
    } t_meta;

    // Divider state handed from cell to cell
    typedef struct packed {
        t_meta                meta;
        logic [DEN_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [LUX_W-1:0]     numq;     // low numerator bits out, quotient bits in
    } t_div;

    // Integration time in ms; codes above 5 mean 100 ms
    function automatic logic [TMS_W-1:0] time_ms(input logic [TCODE_W-1:0] code);
        logic [TMS_W-1:0] ms;
        case (code)
            3'd0:    ms = 10'd100;
            3'd1:    ms = 10'd200;
            3'd2:    ms = 10'd300;
            3'd3:    ms = 10'd400;
            3'd4:    ms = 10'd500;
            3'd5:    ms = 10'd600;
            default: ms = 10'd100;
        endcase
        return ms;
    endfunction

    // Analog gain, doubled so that 24.5x stays integral
    function automatic logic [GAIN_W-1:0] gain2(input logic [GCODE_W-1:0] code);
        logic [GAIN_W-1:0] g;
        case (code)
            2'd0:    g = 15'd2;
            2'd1:    g = 15'd49;
            2'd2:    g = 15'd800;
            default: g = 15'd18400;
        endcase
        return g;
    endfunction

endpackage

// File: hdl/alc_front.sv
// Front end of the lux calculator: status, visible count and the two
// products that form numerator and denominator. Three registered stages.
// Depends on alc_pkg.
module alc_front #(
    parameter int COUNT_MAX = alc_pkg::COUNT_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // upstream
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [alc_pkg::COUNT_W-1:0]   i_full,
    input  logic [alc_pkg::COUNT_W-1:0]   i_ir,
    input  logic                          i_data_ok,
    input  logic [alc_pkg::TCODE_W-1:0]   i_time_code,
    input  logic [alc_pkg::GCODE_W-1:0]   i_gain_code,
    input  logic [alc_pkg::DF_W-1:0]      i_df,
    // downstream, to the first divider cell
    output logic                          o_valid,
    input  logic                          i_ready,
    output alc_pkg::t_div                 o_div
);

    localparam logic [alc_pkg::COUNT_W-1:0] CMAX = alc_pkg::COUNT_W'(COUNT_MAX);

    // Stage 1 registers
    logic                          r_v1;
    alc_pkg::t_meta                r_meta1;
    logic [alc_pkg::SQ_W-1:0]      r_vis_sq;
    logic [alc_pkg::COUNT_W-1:0]   r_full1;
    logic [alc_pkg::K_W-1:0]       r_k;
    logic [alc_pkg::DF_W-1:0]      r_df;
    // Stage 2 registers
    logic                          r_v2;
    alc_pkg::t_meta                r_meta2;
    logic [alc_pkg::NUM_W-1:0]     r_num;
    logic [alc_pkg::DEN_W-1:0]     r_den;
    // Stage 3 registers
    logic                          r_v3;
    alc_pkg::t_div                 r_div;

    logic                          rdy1, rdy2, rdy3;
    logic [alc_pkg::COUNT_W-1:0]   vis;
    logic                          ovf;
    alc_pkg::t_meta                n_meta1;
    logic [alc_pkg::K_W+1-1:0]     k_full;
    logic [alc_pkg::SQ_W+alc_pkg::DF_W-1:0] prod_num;
    alc_pkg::t_meta                n_meta2;
    alc_pkg::t_div                 n_div;

    // Stage-level flow control: a stage loads when empty or draining
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_div   = r_div;

    // Stage 1 logic: classify, form visible count and the time-gain product
    always_comb begin
        vis = (i_ir > i_full) ? '0 : (i_full - i_ir);
        ovf = (i_full >= CMAX) || (i_ir >= CMAX);
        n_meta1.sat = 1'b0;
        if (!i_data_ok) begin
            n_meta1.status = alc_pkg::ST_INVALID;
            n_meta1.vis    = '0;
        end else if (ovf) begin
            n_meta1.status = alc_pkg::ST_OVERFLOW;
            n_meta1.vis    = vis;
        end else begin
            n_meta1.status = alc_pkg::ST_OK;
            n_meta1.vis    = vis;
        end
        n_meta1.force_zero = !i_data_ok || ovf || (i_full == '0) || (i_df == '0);
        k_full = alc_pkg::time_ms(i_time_code) * alc_pkg::gain2(i_gain_code);
    end

    // Stage 2 logic: numerator product
    assign prod_num = r_vis_sq * r_df;
    always_comb begin
        n_meta2 = r_meta1;
    end

    // Stage 3 logic: saturation check and divider seed
    always_comb begin
        n_div.meta     = r_meta2;
        n_div.meta.sat = {{(alc_pkg::DEN_W-alc_pkg::HI_W){1'b0}},
                          r_num[alc_pkg::NUM_W-1 -: alc_pkg::HI_W]} >= r_den;
        n_div.rem      = {{(alc_pkg::DEN_W-alc_pkg::HI_W){1'b0}},
                          r_num[alc_pkg::NUM_W-1 -: alc_pkg::HI_W]};
        n_div.den      = r_den;
        n_div.numq     = r_num[alc_pkg::LUX_W-1:0];
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_meta1  <= n_meta1;
            r_vis_sq <= vis * vis;
            r_full1  <= i_full;
            r_k      <= k_full[alc_pkg::K_W-1:0];
            r_df     <= i_df;
        end
        if (rdy2 && r_v1) begin
            r_meta2 <= n_meta2;
            r_num   <= {prod_num, {alc_pkg::NUM_SHIFT{1'b0}}};
            r_den   <= r_full1 * r_k;
        end
        if (rdy3 && r_v2) begin
            r_div <= n_div;
        end
    end

endmodule

// File: hdl/alc_div_cell.sv
// One restoring-division cell: resolves one quotient bit per item and
// hands the partial remainder to its neighbor. Depends on alc_pkg.
module alc_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  alc_pkg::t_div   i_div,
    output logic            o_valid,
    input  logic            i_ready,
    output alc_pkg::t_div   o_div
);

    logic                          r_valid;
    alc_pkg::t_div                 r_div;
    logic                          rdy;
    logic [alc_pkg::DEN_W:0]       trial;
    logic [alc_pkg::DEN_W:0]       diff;
    logic                          ge;
    alc_pkg::t_div                 n_div;

    assign rdy     = !r_valid || i_ready;
    assign o_ready = rdy;
    assign o_valid = r_valid;
    assign o_div   = r_div;

    // Shift in the next numerator bit, subtract if it fits
    always_comb begin
        trial      = {i_div.rem, i_div.numq[alc_pkg::LUX_W-1]};
        diff       = trial - {1'b0, i_div.den};
        ge         = trial >= {1'b0, i_div.den};
        n_div      = i_div;
        n_div.rem  = ge ? diff[alc_pkg::DEN_W-1:0] : trial[alc_pkg::DEN_W-1:0];
        n_div.numq = {i_div.numq[alc_pkg::LUX_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_div <= n_div;
        end
    end

endmodule

// File: hdl/ambient_light_lux_calc.sv
// Ambient light lux calculator, top level.
// Input channel: i_in_valid / o_in_stall carry full spectrum count, infrared
// count and the sensor's data-valid flag; a transaction happens at a clock
// edge with valid high and stall low. Output channel: o_out_valid /
// i_out_stall carry status, visible count and lux in 1/256 lux units.
// Configuration: i_cfg_valid / o_cfg_ready write time_code (0), gain_code (1)
// or lux_df (2); other indexes are ignored. Write only while no item is in
// flight. The port is always ready.
// Path from input to output: three front stages (classify, multiply,
// saturation check), 32 divider cells each resolving one quotient bit,
// and the output register. One item enters per cycle unless o_in_stall is
// high; every stage holds its own valid, so bubbles close up and a new item
// is taken while a result waits at a stalled output, until the chain is full.
// Synchronous reset empties the chain and loads time_code 5, gain_code 0
// and lux_df 408. While the receiver stalls the output holds steady.
// Depends on alc_pkg, alc_front and alc_div_cell.
module ambient_light_lux_calc #(
    parameter int COUNT_MAX = alc_pkg::COUNT_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [alc_pkg::COUNT_W-1:0]     i_full_count,
    input  logic [alc_pkg::COUNT_W-1:0]     i_infrared_count,
    input  logic                            i_data_valid,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [alc_pkg::STATUS_W-1:0]    o_status,
    output logic [alc_pkg::COUNT_W-1:0]     o_visible_count,
    output logic [alc_pkg::LUX_W-1:0]       o_lux_value,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [alc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [alc_pkg::DF_W-1:0]        i_cfg_data
);

    localparam int NCELL = alc_pkg::LUX_W;

    // Configuration registers
    logic [alc_pkg::TCODE_W-1:0]  r_time_code;
    logic [alc_pkg::GCODE_W-1:0]  r_gain_code;
    logic [alc_pkg::DF_W-1:0]     r_lux_df;

    // Chain links
    logic                         c_valid [NCELL+1];
    logic                         c_ready [NCELL+1];
    alc_pkg::t_div                c_div   [NCELL+1];

    logic                         front_ready;

    // Output register
    logic                         r_out_valid;
    logic [alc_pkg::STATUS_W-1:0] r_status;
    logic [alc_pkg::COUNT_W-1:0]  r_vis;
    logic [alc_pkg::LUX_W-1:0]    r_lux;
    logic                         out_rdy;
    logic [alc_pkg::LUX_W-1:0]    n_lux;

    // Config writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_code <= 3'd5;
            r_gain_code <= 2'd0;
            r_lux_df    <= 10'd408;
        end else if (i_cfg_valid) begin
            unique case (alc_pkg::t_cfg_idx'(i_cfg_index))
                alc_pkg::CFG_TIME_CODE: r_time_code <= i_cfg_data[alc_pkg::TCODE_W-1:0];
                alc_pkg::CFG_GAIN_CODE: r_gain_code <= i_cfg_data[alc_pkg::GCODE_W-1:0];
                alc_pkg::CFG_LUX_DF:    r_lux_df    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end
    alc_front #(
        .COUNT_MAX (COUNT_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (front_ready),
        .i_full      (i_full_count),
        .i_ir        (i_infrared_count),
        .i_data_ok   (i_data_valid),
        .i_time_code (r_time_code),
        .i_gain_code (r_gain_code),
        .i_df        (r_lux_df),
        .o_valid     (c_valid[0]),
        .i_ready     (c_ready[0]),
        .o_div       (c_div[0])
    );
    assign o_in_stall = !front_ready;

    // Divider chain, most significant quotient bit first
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        alc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_div   (c_div[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_div   (c_div[g+1])
        );
    end

    // Final lux: zero unless ok, all ones on saturation
    always_comb begin
        if (c_div[NCELL].meta.force_zero) begin
            n_lux = '0;
        end else if (c_div[NCELL].meta.sat) begin
            n_lux = '1;
        end else begin
            n_lux = c_div[NCELL].numq;
        end
    end

    // Output stage
    assign out_rdy       = !r_out_valid || !i_out_stall;
    assign c_ready[NCELL] = out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= c_valid[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && c_valid[NCELL]) begin
            r_status <= c_div[NCELL].meta.status;
            r_vis    <= c_div[NCELL].meta.vis;
            r_lux    <= n_lux;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_visible_count = r_vis;
    assign o_lux_value     = r_lux;

endmodule

// File: tb/ambient_light_lux_calc_tb.sv
// Self-checking testbench for ambient_light_lux_calc: status, visible count
// and lux per channel pair, checked against an in-bench integer predictor.
// Depends on alc_pkg and the ambient_light_lux_calc RTL.
module ambient_light_lux_calc_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_LIMIT  = alc_pkg::COUNT_MAX_DEF;
    localparam int QUIET_LIMIT  = 4000;   // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 40;     // pipeline latency plus margin
    localparam int MAX_REPORTS  = 40;
    localparam int PHASES       = 26;
    localparam int PHASE_ITEMS  = 50;

    // register index that decodes to nothing
    localparam logic [alc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // register values after reset
    localparam logic [alc_pkg::TCODE_W-1:0] RST_TIME_CODE = 3'd5;
    localparam logic [alc_pkg::GCODE_W-1:0] RST_GAIN_CODE = 2'd0;
    localparam logic [alc_pkg::DF_W-1:0]    RST_LUX_DF    = 10'd408;

    typedef struct packed {
        alc_pkg::t_status              status;
        logic [alc_pkg::COUNT_W-1:0]   vis;
        logic [alc_pkg::LUX_W-1:0]     lux;
    } t_lux_reading;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [alc_pkg::COUNT_W-1:0]        i_full_count;
    logic [alc_pkg::COUNT_W-1:0]        i_infrared_count;
    logic                               i_data_valid;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic [alc_pkg::STATUS_W-1:0]       o_status;
    logic [alc_pkg::COUNT_W-1:0]        o_visible_count;
    logic [alc_pkg::LUX_W-1:0]          o_lux_value;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [alc_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [alc_pkg::DF_W-1:0]           i_cfg_data;

    // shadow of the register file
    logic [alc_pkg::TCODE_W-1:0]        shadow_time_code;
    logic [alc_pkg::GCODE_W-1:0]        shadow_gain_code;
    logic [alc_pkg::DF_W-1:0]           shadow_lux_df;

    t_lux_reading           awaited_readings[$];
    int unsigned            mismatches;
    bit                     calm;     // no idling on either side while set

    ambient_light_lux_calc dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_full_count     (i_full_count),
        .i_infrared_count (i_infrared_count),
        .i_data_valid     (i_data_valid),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_visible_count  (o_visible_count),
        .o_lux_value      (o_lux_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Predictor: exact integer lux, one truncation, saturated to 32 bits
    function automatic t_lux_reading compute_lux_reading(
        input logic [alc_pkg::COUNT_W-1:0] full,
        input logic [alc_pkg::COUNT_W-1:0] ir,
        input logic                        dv
    );
        t_lux_reading   r;
        logic [63:0]    num;
        logic [63:0]    den;
        logic [63:0]    quot;
        logic [63:0]    t_units;
        logic [63:0]    gain_x2;
        logic [alc_pkg::COUNT_W-1:0] vis;

        vis = (ir > full) ? '0 : full - ir;
        t_units = (shadow_time_code <= 3'd5) ? 64'(shadow_time_code) + 64'd1
                                             : 64'd1;
        case (shadow_gain_code)
            2'd0:    gain_x2 = 64'd2;
            2'd1:    gain_x2 = 64'd49;
            2'd2:    gain_x2 = 64'd800;
            default: gain_x2 = 64'd18400;
        endcase

        r.status = alc_pkg::ST_OK;
        r.vis    = vis;
        r.lux    = '0;
        if (!dv) begin
            r.status = alc_pkg::ST_INVALID;
            r.vis    = '0;
        end else if (full >= COUNT_LIMIT || ir >= COUNT_LIMIT) begin
            r.status = alc_pkg::ST_OVERFLOW;
        end else if (full != 0 && vis != 0 && shadow_lux_df != 0) begin
            num  = 64'd512 * 64'(vis) * 64'(vis) * 64'(shadow_lux_df);
            den  = 64'(full) * 64'd100 * t_units * gain_x2;
            quot = num / den;
            r.lux = (quot > 64'hFFFF_FFFF) ? '1 : quot[alc_pkg::LUX_W-1:0];
        end
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endtask

    // Result checker: every output transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_lux_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: unexpected result, expected none",
                              " actual status %0d vis %0d lux %0d"},
                             $time, o_status, o_visible_count, o_lux_value);
            end else begin
                want = awaited_readings.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_visible_count !== want.vis)
                    note_mismatch("visible_count", 32'(want.vis), 32'(o_visible_count));
                if (o_lux_value !== want.lux)
                    note_mismatch("lux_value", want.lux, o_lux_value);
            end
        end
    end

    // Receiver back-pressure
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= !calm && ($urandom_range(99) < 7);
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("ambient_light_lux_calc_tb: errors");
        $finish;
    end

    // Send one channel pair; the expectation is queued when it is taken
    task automatic send_reading(input logic [alc_pkg::COUNT_W-1:0] full,
                                input logic [alc_pkg::COUNT_W-1:0] ir,
                                input logic dv);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_full_count     <= full;
        i_infrared_count <= ir;
        i_data_valid     <= dv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        awaited_readings.push_back(compute_lux_reading(full, ir, dv));
    endtask

    // Stop sending and wait for every result to come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [alc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [alc_pkg::DF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            alc_pkg::CFG_TIME_CODE: shadow_time_code = data[alc_pkg::TCODE_W-1:0];
            alc_pkg::CFG_GAIN_CODE: shadow_gain_code = data[alc_pkg::GCODE_W-1:0];
            alc_pkg::CFG_LUX_DF:    shadow_lux_df    = data;
            default:                ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [alc_pkg::TCODE_W-1:0] tc,
                              input logic [alc_pkg::GCODE_W-1:0] gc,
                              input logic [alc_pkg::DF_W-1:0] df);
        wait_idle();
        write_reg(alc_pkg::CFG_TIME_CODE, alc_pkg::DF_W'(tc));
        write_reg(alc_pkg::CFG_GAIN_CODE, alc_pkg::DF_W'(gc));
        write_reg(alc_pkg::CFG_LUX_DF, df);
    endtask

    // Status priority: invalid over overflow over ok, at reset settings
    task automatic test_status_codes();
        send_reading(16'd100,   16'd20,    1'b0);
        send_reading(16'hFFFF,  16'd20,    1'b0);
        send_reading(16'hFFFF,  16'd0,     1'b1);
        send_reading(16'd0,     16'hFFFF,  1'b1);
        send_reading(16'hFFFF,  16'hFFFF,  1'b1);
        send_reading(16'hFFFF,  16'hFFFE,  1'b1);
        send_reading(16'hFFFE,  16'hFFFE,  1'b1);
    endtask

    // Lux corner values: zero full, infrared above full, largest counts
    task automatic test_lux_extremes();
        send_reading(16'd0,     16'd0,     1'b1);
        send_reading(16'd1,     16'd0,     1'b1);
        send_reading(16'hFFFE,  16'd0,     1'b1);
        send_reading(16'd300,   16'd301,   1'b1);
        send_reading(16'd1000,  16'd999,   1'b1);
        send_reading(16'hAAAA,  16'h5555,  1'b1);
        send_reading(16'h5555,  16'h2AAA,  1'b1);
    endtask

    // Register extremes, time codes past 5, zero coefficient, spare index
    task automatic test_register_extremes();
        set_config(3'd0, 2'd0, 10'd1023);
        send_reading(16'hFFFE,  16'd0,     1'b1);
        send_reading(16'd1,     16'd0,     1'b1);
        set_config(3'd7, 2'd3, 10'd1);
        send_reading(16'hFFFE,  16'd0,     1'b1);
        send_reading(16'd2,     16'd1,     1'b1);
        set_config(3'd6, 2'd1, 10'd0);
        send_reading(16'd5000,  16'd100,   1'b1);
        set_config(3'd4, 2'd2, 10'd700);
        write_reg(CFG_SPARE, 10'h3FF);
        send_reading(16'd60000, 16'd1000,  1'b1);
    endtask

    // Random traffic in phases, each under its own register setting
    task automatic test_random_traffic();
        logic [alc_pkg::COUNT_W-1:0] full;
        logic [alc_pkg::COUNT_W-1:0] ir;
        logic                        dv;
        logic [alc_pkg::DF_W-1:0]    df;
        int unsigned                 pick;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       set_config(3'd0, 2'd0, 10'd1023);
                1:       set_config(3'd7, 2'd3, 10'd1);
                2:       set_config(3'd5, 2'd2, 10'd0);
                default: begin
                    pick = $urandom_range(9);
                    df = (pick == 0) ? 10'd1023 : (pick == 1) ? 10'd1
                                                 : alc_pkg::DF_W'($urandom_range(1023, 1));
                    set_config(alc_pkg::TCODE_W'($urandom_range(7)),
                               alc_pkg::GCODE_W'($urandom_range(3)), df);
                end
            endcase
            calm = (phase >= 10 && phase <= 12);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                full = alc_pkg::COUNT_W'($urandom_range(COUNT_LIMIT - 1)
                                         >> $urandom_range(15));
                ir   = alc_pkg::COUNT_W'($urandom_range(full));
                dv   = 1'b1;
                if (pick >= 70 && pick < 80) begin
                    ir = alc_pkg::COUNT_W'($urandom);
                end else if (pick >= 80 && pick < 87) begin
                    if ($urandom_range(1)) full = '1;
                    else ir = '1;
                end else if (pick >= 87 && pick < 94) begin
                    full = alc_pkg::COUNT_W'($urandom);
                    ir   = alc_pkg::COUNT_W'($urandom);
                    dv   = 1'b0;
                end else if (pick >= 94) begin
                    full = alc_pkg::COUNT_W'($urandom_range(2));
                    ir   = alc_pkg::COUNT_W'($urandom_range(2));
                end
                send_reading(full, ir, dv);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_full_count     = '0;
        i_infrared_count = '0;
        i_data_valid     = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = alc_pkg::CFG_TIME_CODE;
        i_cfg_data       = '0;
        shadow_time_code = RST_TIME_CODE;
        shadow_gain_code = RST_GAIN_CODE;
        shadow_lux_df    = RST_LUX_DF;
        mismatches       = 0;
        calm             = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_status_codes();
        test_lux_extremes();
        test_register_extremes();
        test_random_traffic();

        // drain, then let any stray result show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("ambient_light_lux_calc_tb: clean");
        else
            $display("ambient_light_lux_calc_tb: errors");
        $finish;
    end

endmodule
